// ===== rtl/core/gcm_pkg.sv =====
// ----------------------------------------------------------------------------
// gcm_pkg: shared types and constants of the greedy change maker
// Field widths, register indexes, reset values of the denomination table,
// and the denomination slot selector.
// ----------------------------------------------------------------------------
package gcm_pkg;

	localparam int AMOUNT_W = 24;
	localparam int DENOM_W  = 16;
	localparam int SLOT_W   = 4;
	localparam int CFG_W    = 64;
	localparam int CNT_W    = 5;

	// configuration register indexes
	localparam logic [1:0] REG_DENOMS_LOW  = 2'd0;
	localparam logic [1:0] REG_DENOMS_MID  = 2'd1;
	localparam logic [1:0] REG_DENOMS_HIGH = 2'd2;
	localparam logic [1:0] REG_DENOMS_USED = 2'd3;

	// reset table: 10000 5000 200 100 | 50 20 5 2 | 1
	localparam logic [CFG_W-1:0]  RST_DENOMS_LOW  = 64'h0064_00C8_1388_2710;
	localparam logic [CFG_W-1:0]  RST_DENOMS_MID  = 64'h0002_0005_0014_0032;
	localparam logic [CFG_W-1:0]  RST_DENOMS_HIGH = 64'h0000_0000_0000_0001;
	localparam logic [SLOT_W-1:0] RST_DENOMS_USED = 4'd9;

	typedef logic [DENOM_W-1:0]  denom_t;
	typedef logic [AMOUNT_W-1:0] amount_t;

	// one result waiting for its successor to tell whether it is the last
	typedef struct packed {
		logic    valid;
		denom_t  value;
		amount_t count;
	} pend_t;

	// pick the sixteen-bit slot out of the three table words
	function automatic denom_t slot_value(input logic [CFG_W-1:0] lo,
	                                      input logic [CFG_W-1:0] mid,
	                                      input logic [CFG_W-1:0] hi,
	                                      input logic [SLOT_W-1:0] slot);
		logic [CFG_W-1:0] word;
		case (slot[3:2])
			2'd0:    word = lo;
			2'd1:    word = mid;
			2'd2:    word = hi;
			default: word = '0;
		endcase
		return word[slot[1:0]*DENOM_W +: DENOM_W];
	endfunction

endpackage

// ===== rtl/core/greedy_change_maker_top.sv =====
// ----------------------------------------------------------------------------
// greedy_change_maker_top: greedy coin change over a configurable table
// Pays out an amount slot by slot with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// One amount is worked on at a time. The sequencer walks the table slot by
// slot and passes over each slot whose value is zero or larger than the
// remaining amount; each slot that hands out coins goes through the slot
// check, the one-bit-per-cycle divider and the emit step. Closing an amount
// sees the end of the table and then loads the final word.
// A word for a slot is emitted once the next paying slot has been divided, or
// at the end of the table, so the final word of an amount carries tlast and,
// in tuser, the unpaid flag. A new amount is accepted as soon as the final
// word is in the output register, even while it still waits to be taken. A
// stall on the output side holds the sequencer at each paying slot, the first
// one of an amount included, and at the final word, until the output register
// is free.
module greedy_change_maker_top #(
	parameter int MAX_DENOMS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data,
	// amount in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] amount
	// coins out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] coin_value, [39:16] coin_count
	output logic        m_tlast,   // last_of_run
	output logic [0:0]  m_tuser    // [0] no_solution
);

	localparam logic [gcm_pkg::SLOT_W-1:0] MaxUsed = gcm_pkg::SLOT_W'(MAX_DENOMS);
	localparam logic [gcm_pkg::CNT_W-1:0]  LastBit = gcm_pkg::CNT_W'(gcm_pkg::AMOUNT_W - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SLOT  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_FINAL = 3'd4;

	logic [63:0] denoms_low_q, denoms_mid_q, denoms_high_q;
	logic [gcm_pkg::SLOT_W-1:0] denoms_used_q;

	logic [2:0]                    state_q;
	logic [gcm_pkg::SLOT_W-1:0]    slot_q, used_q;
	gcm_pkg::amount_t              rest_q;
	gcm_pkg::amount_t              quot_q;
	gcm_pkg::denom_t               part_q, div_d_q;
	logic [gcm_pkg::CNT_W-1:0]     bit_cnt_q;
	gcm_pkg::pend_t                pend_q;

	logic                          out_valid_q;
	gcm_pkg::denom_t               out_value_q;
	gcm_pkg::amount_t              out_count_q;
	logic                          out_last_q, out_nosol_q;

	gcm_pkg::denom_t               cur_d;
	logic [gcm_pkg::DENOM_W:0]     trial;
	logic                          qbit;
	logic                          can_push;
	logic                          push_out;

	assign cur_d    = gcm_pkg::slot_value(denoms_low_q, denoms_mid_q, denoms_high_q, slot_q);
	assign trial    = {part_q, quot_q[gcm_pkg::AMOUNT_W-1]};
	assign qbit     = (trial >= {1'b0, div_d_q});
	assign can_push = !out_valid_q || m_tready;
	assign push_out = can_push &&
	                  ((state_q == S_EMIT && pend_q.valid) || state_q == S_FINAL);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_value_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_nosol_q;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			denoms_low_q  <= gcm_pkg::RST_DENOMS_LOW;
			denoms_mid_q  <= gcm_pkg::RST_DENOMS_MID;
			denoms_high_q <= gcm_pkg::RST_DENOMS_HIGH;
			denoms_used_q <= gcm_pkg::RST_DENOMS_USED;
		end else if (wr_en) begin
			case (wr_index)
				gcm_pkg::REG_DENOMS_LOW:  denoms_low_q  <= wr_data;
				gcm_pkg::REG_DENOMS_MID:  denoms_mid_q  <= wr_data;
				gcm_pkg::REG_DENOMS_HIGH: denoms_high_q <= wr_data;
				gcm_pkg::REG_DENOMS_USED: denoms_used_q <= wr_data[gcm_pkg::SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer control state and pending word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load the output word on a push, drop it once taken
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_SLOT;
					end
				end
				S_SLOT: begin
					if (slot_q == used_q) begin
						state_q <= S_FINAL;
					end else if (cur_d != '0 && {8'd0, cur_d} <= rest_q) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (bit_cnt_q == LastBit) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (can_push) begin
						pend_q  <= '{valid: 1'b1, value: div_d_q, count: quot_q};
						state_q <= S_SLOT;
					end
				end
				S_FINAL: begin
					if (can_push) begin
						pend_q.valid <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: remainder, bit-serial divider and output word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rest_q <= s_tdata;
				slot_q <= '0;
				used_q <= (denoms_used_q > MaxUsed) ? MaxUsed : denoms_used_q;
			end
			S_SLOT: begin
				if (slot_q != used_q) begin
					if (cur_d != '0 && {8'd0, cur_d} <= rest_q) begin
						quot_q    <= rest_q;
						part_q    <= '0;
						div_d_q   <= cur_d;
						bit_cnt_q <= '0;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
			end
			S_DIV: begin
				// shift one dividend bit in, one quotient bit out
				part_q    <= qbit ? gcm_pkg::DENOM_W'(trial - {1'b0, div_d_q})
				                  : trial[gcm_pkg::DENOM_W-1:0];
				quot_q    <= {quot_q[gcm_pkg::AMOUNT_W-2:0], qbit};
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
			S_EMIT: begin
				if (can_push) begin
					out_value_q  <= pend_q.value;
					out_count_q  <= pend_q.count;
					out_last_q   <= 1'b0;
					out_nosol_q  <= 1'b0;
					rest_q       <= {8'd0, part_q};
					slot_q       <= slot_q + 1'b1;
				end
			end
			S_FINAL: begin
				if (can_push) begin
					out_value_q <= pend_q.valid ? pend_q.value : '0;
					out_count_q <= pend_q.valid ? pend_q.count : '0;
					out_last_q  <= 1'b1;
					out_nosol_q <= (rest_q != '0);
				end
			end
			default: ;
		endcase
	end

	// the divider only runs on a nonzero denomination
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_d_q != '0))
		else $error("divider running with zero denomination");

	// partial remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (part_q < div_d_q))
		else $error("partial remainder out of range");

	// nothing left over from the previous amount when a new one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_q.valid)
		else $error("pending word left at accept");

	// a pushed final word is marked last
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINAL && can_push) |=> (m_tvalid && m_tlast))
		else $error("final word not marked last");

endmodule

// ===== tb/greedy_change_maker_top_tb.sv =====
// ----------------------------------------------------------------------------
// greedy_change_maker_top_tb: self-checking bench for the greedy change maker
// Walks a short table of directed amounts and register writes, then random
// denomination tables and amounts. Every coin word is checked against a
// fixed expectation or a predictor that pays out over the bench table.
// ----------------------------------------------------------------------------
module greedy_change_maker_top_tb;

	localparam int          SLOTS       = 12;
	localparam int          HOLD_CYCLES = 2000;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	// one coin word: value, count, end of run, unpaid remainder
	typedef struct packed {
		gcm_pkg::denom_t  value;
		gcm_pkg::amount_t count;
		logic             last;
		logic             nosol;
	} coin_word_t;

	typedef enum bit {ROW_AMOUNT, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [1:0]       idx;
		logic [63:0]      data;
		gcm_pkg::amount_t amt;
		bit               typed;
		coin_word_t       want;
	} plan_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        wr_en    = 1'b0;
	logic [1:0]  wr_index = gcm_pkg::REG_DENOMS_LOW;
	logic [63:0] wr_data  = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // [23:0] amount
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // [15:0] coin_value, [39:16] coin_count
	logic        m_tlast;         // last_of_run
	logic [0:0]  m_tuser;         // [0] no_solution

	// bench copy of the denomination table
	logic [gcm_pkg::CFG_W-1:0]  tbl_lo   = gcm_pkg::RST_DENOMS_LOW;
	logic [gcm_pkg::CFG_W-1:0]  tbl_mid  = gcm_pkg::RST_DENOMS_MID;
	logic [gcm_pkg::CFG_W-1:0]  tbl_hi   = gcm_pkg::RST_DENOMS_HIGH;
	logic [gcm_pkg::SLOT_W-1:0] tbl_used = gcm_pkg::RST_DENOMS_USED;

	coin_word_t  coin_q[$];
	int          mismatches = 0;
	int          burst_left = 0;
	bit          hold_go    = 1'b0;
	bit          hold_taken = 1'b0;
	int          hold_left  = 0;
	rx_mode_t    rx_mode    = RX_OPEN;
	int          mode_left  = 0;
	int unsigned cycle_cnt  = 0;

	greedy_change_maker_top #(
		.MAX_DENOMS(SLOTS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// append one expected coin word
	function automatic void queue_coin(input coin_word_t w);
		coin_q = {coin_q, w};
	endfunction

	// pay out one amount greedily over the bench table, queue its coin words
	function automatic void predict_payout(input gcm_pkg::amount_t amt);
		coin_word_t                run[SLOTS];
		gcm_pkg::amount_t          rest;
		gcm_pkg::amount_t          q;
		gcm_pkg::denom_t           d;
		logic [gcm_pkg::CFG_W-1:0] word;
		int                        walk;
		int                        n;
		rest = amt;
		n    = 0;
		walk = (tbl_used > SLOTS) ? SLOTS : int'(tbl_used);
		for (int s = 0; s < walk; s++) begin
			word = (s < 4) ? tbl_lo : (s < 8) ? tbl_mid : tbl_hi;
			d    = word[(s % 4) * gcm_pkg::DENOM_W +: gcm_pkg::DENOM_W];
			if (d != 0) begin
				q = rest / d;
				if (q != 0) begin
					run[n] = '{value: d, count: q, last: 1'b0, nosol: 1'b0};
					n++;
					rest = rest % d;
				end
			end
		end
		if (n == 0) begin
			queue_coin('{value: '0, count: '0, last: 1'b1, nosol: rest != 0});
		end else begin
			run[n-1].last  = 1'b1;
			run[n-1].nosol = rest != 0;
			for (int k = 0; k < n; k++) queue_coin(run[k]);
		end
	endfunction

	function automatic plan_row_t pay_row(input gcm_pkg::amount_t amt);
		return '{ROW_AMOUNT, gcm_pkg::REG_DENOMS_LOW, '0, amt, 1'b0, '0};
	endfunction

	function automatic plan_row_t known_row(input gcm_pkg::amount_t amt,
	                                        input gcm_pkg::denom_t value,
	                                        input gcm_pkg::amount_t count,
	                                        input logic nosol);
		return '{ROW_AMOUNT, gcm_pkg::REG_DENOMS_LOW, '0, amt, 1'b1,
		         '{value: value, count: count, last: 1'b1, nosol: nosol}};
	endfunction

	function automatic plan_row_t write_row(input logic [1:0] idx, input logic [63:0] data);
		return '{ROW_WRITE, idx, data, '0, 1'b0, '0};
	endfunction

	function automatic gcm_pkg::amount_t pick_amount();
		case ($urandom_range(0, 4))
			0:       return gcm_pkg::amount_t'($urandom);
			1:       return gcm_pkg::amount_t'($urandom_range(0, 300));
			2:       return gcm_pkg::amount_t'($urandom_range(0, 70000));
			3:       return gcm_pkg::amount_t'($urandom_range(0, 1 << 20));
			default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
		endcase
	endfunction

	// offer one amount inside a burst; queue its coin words once taken
	task automatic send_amount(input gcm_pkg::amount_t amt, input bit typed,
	                           input coin_word_t want);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
			                                         : $urandom_range(1, 12);
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= amt;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (typed)
			queue_coin(want);
		else
			predict_payout(amt);
	endtask

	// write one register once every coin word is out and the block is idle
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (coin_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			gcm_pkg::REG_DENOMS_LOW:  tbl_lo   = data;
			gcm_pkg::REG_DENOMS_MID:  tbl_mid  = data;
			gcm_pkg::REG_DENOMS_HIGH: tbl_hi   = data;
			gcm_pkg::REG_DENOMS_USED: tbl_used = data[gcm_pkg::SLOT_W-1:0];
			default: ;
		endcase
	endtask

	// receiver: random stall modes, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(16, 128);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN:  m_tready <= 1'b1;
				RX_LIGHT: m_tready <= $urandom_range(0, 3) != 0;
				RX_HALF:  m_tready <= $urandom_range(0, 1) != 0;
				RX_HEAVY: m_tready <= $urandom_range(0, 7) == 0;
				default:  m_tready <= 1'b1;
			endcase
		end
	end

	// compare each taken word with the oldest expectation
	always @(posedge clk) begin
		coin_word_t want;
		if (m_tvalid && m_tready) begin
			if (coin_q.size() == 0) begin
				report_mismatch("unexpected word", m_tdata, 0);
			end else begin
				want = coin_q.pop_front();
				if (m_tdata[15:0] !== want.value)
					report_mismatch("coin_value", m_tdata[15:0], want.value);
				if (m_tdata[39:16] !== want.count)
					report_mismatch("coin_count", m_tdata[39:16], want.count);
				if (m_tlast !== want.last)
					report_mismatch("last_of_run", m_tlast, want.last);
				if (m_tuser[0] !== want.nosol)
					report_mismatch("no_solution", m_tuser[0], want.nosol);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		plan_row_t       plan[$];
		gcm_pkg::denom_t slots[SLOTS];
		int unsigned     v;
		logic [63:0]     used_data;

		// reset table first, then slot count zero, saturation, unsorted and
		// all-ones tables
		plan = {plan, known_row(24'd0, 16'd0, 24'd0, 1'b0)};
		plan = {plan, known_row(24'd1, 16'd1, 24'd1, 1'b0)};
		plan = {plan, known_row(24'd10000, 16'd10000, 24'd1, 1'b0)};
		plan = {plan, pay_row(24'hFFFFFF)};
		plan = {plan, pay_row(24'd18888)};
		plan = {plan, pay_row(24'hAAAAAA)};
		plan = {plan, pay_row(24'h555555)};
		plan = {plan, write_row(gcm_pkg::REG_DENOMS_USED, 64'd0)};
		plan = {plan, known_row(24'd7, 16'd0, 24'd0, 1'b1)};
		plan = {plan, known_row(24'd0, 16'd0, 24'd0, 1'b0)};
		plan = {plan, write_row(gcm_pkg::REG_DENOMS_LOW, 64'hFFFF_0000_0100_0040)};
		plan = {plan, write_row(gcm_pkg::REG_DENOMS_MID, 64'd0)};
		plan = {plan, write_row(gcm_pkg::REG_DENOMS_HIGH, 64'h0003_0000_0007_0000)};
		plan = {plan, write_row(gcm_pkg::REG_DENOMS_USED, 64'hFFFF_FFFF_FFFF_FFFF)};
		plan = {plan, pay_row(24'd100000)};
		plan = {plan, known_row(24'd2, 16'd0, 24'd0, 1'b1)};
		plan = {plan, pay_row(24'hFFFFFF)};
		plan = {plan, write_row(gcm_pkg::REG_DENOMS_USED, 64'd1)};
		plan = {plan, known_row(24'd197, 16'd64, 24'd3, 1'b1)};
		plan = {plan, known_row(24'd63, 16'd0, 24'd0, 1'b1)};
		plan = {plan, write_row(gcm_pkg::REG_DENOMS_LOW, 64'hFFFF_FFFF_FFFF_FFFF)};
		plan = {plan, write_row(gcm_pkg::REG_DENOMS_USED, 64'd4)};
		plan = {plan, known_row(24'hFFFFFF, 16'hFFFF, 24'd256, 1'b1)};
		plan = {plan, known_row(24'd65535, 16'hFFFF, 24'd1, 1'b0)};
		plan = {plan, write_row(gcm_pkg::REG_DENOMS_USED, 64'd12)};
		plan = {plan, pay_row(24'h123456)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_amount(plan[i].amt, plan[i].typed, plan[i].want);
		end

		// random phases: the reset table first, then mostly descending tables ending
		// in small coins, one phase of raw random words
		for (int phase = 0; phase < 6; phase++) begin
			v = (phase % 2 == 0) ? $urandom_range(1, 1000) : $urandom_range(1, 65535);
			for (int s = 0; s < SLOTS; s++) begin
				slots[s] = ($urandom_range(0, 9) == 0) ? '0 : gcm_pkg::denom_t'(v);
				v = v / $urandom_range(1, 4);
				if (v == 0) v = 1;
			end
			used_data = (phase == 1) ? 64'd12 : 64'($urandom_range(1, 12));
			if (phase == 0) begin
				write_reg(gcm_pkg::REG_DENOMS_LOW, gcm_pkg::RST_DENOMS_LOW);
				write_reg(gcm_pkg::REG_DENOMS_MID, gcm_pkg::RST_DENOMS_MID);
				write_reg(gcm_pkg::REG_DENOMS_HIGH, gcm_pkg::RST_DENOMS_HIGH);
				write_reg(gcm_pkg::REG_DENOMS_USED, 64'(gcm_pkg::RST_DENOMS_USED));
			end else if (phase == 3) begin
				write_reg(gcm_pkg::REG_DENOMS_LOW, {$urandom, $urandom});
				write_reg(gcm_pkg::REG_DENOMS_MID, {$urandom, $urandom});
				write_reg(gcm_pkg::REG_DENOMS_HIGH, {$urandom, $urandom});
				write_reg(gcm_pkg::REG_DENOMS_USED, {$urandom, $urandom});
			end else begin
				write_reg(gcm_pkg::REG_DENOMS_LOW, {slots[3], slots[2], slots[1], slots[0]});
				write_reg(gcm_pkg::REG_DENOMS_MID, {slots[7], slots[6], slots[5], slots[4]});
				write_reg(gcm_pkg::REG_DENOMS_HIGH,
				          {slots[11], slots[10], slots[9], slots[8]});
				write_reg(gcm_pkg::REG_DENOMS_USED, used_data);
			end
			// hold off the receiver so the block backs up into its input
			if (phase == 2) hold_go = 1'b1;
			repeat (60) send_amount(pick_amount(), 1'b0, '0);
		end

		s_tvalid <= 1'b0;
		while (coin_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== greedy_change_maker_top.f =====
rtl/core/gcm_pkg.sv
rtl/core/greedy_change_maker_top.sv
tb/greedy_change_maker_top_tb.sv
